// ----- src/psm_pkg.sv -----
package psm_pkg;

  // source count and sizes
  localparam int MAX_SOURCES  = 4;
  localparam int SOURCE_COUNT = 4;
  localparam int SAMPLE_W     = 16;
  localparam int GAIN_W       = 9;
  localparam int GAIN_SHIFT   = 8;

  // signed sample times zero-extended gain
  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
  // product after the shift by GAIN_SHIFT, sign bit of the product dropped
  localparam int TERM_W = PROD_W - GAIN_SHIFT - 1;
  localparam int PAIR_COUNT = MAX_SOURCES / 2;
  localparam int PAIR_W = TERM_W + 1;
  localparam int SUM_W  = TERM_W + $clog2(MAX_SOURCES);

  // gain register file
  localparam int REG_COUNT = 2 * MAX_SOURCES;
  localparam int REG_IDX_W = $clog2(REG_COUNT);
  localparam int CFG_IDX_W = REG_IDX_W + 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [GAIN_W-1:0]   gain_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [TERM_W-1:0]   term_t;
  typedef logic signed [PAIR_W-1:0]   pair_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic        [REG_IDX_W-1:0] reg_idx_t;

  // output rails
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

endpackage

// ----- src/psm_in_if.sv -----
interface psm_in_if;
  logic              valid;
  logic              ready;
  psm_pkg::sample_t  src0_left;
  psm_pkg::sample_t  src0_right;
  psm_pkg::sample_t  src1_left;
  psm_pkg::sample_t  src1_right;
  psm_pkg::sample_t  src2_left;
  psm_pkg::sample_t  src2_right;
  psm_pkg::sample_t  src3_left;
  psm_pkg::sample_t  src3_right;

  modport source (
    output valid, src0_left, src0_right, src1_left, src1_right,
           src2_left, src2_right, src3_left, src3_right,
    input  ready
  );
  modport sink (
    input  valid, src0_left, src0_right, src1_left, src1_right,
           src2_left, src2_right, src3_left, src3_right,
    output ready
  );
endinterface

// ----- src/psm_out_if.sv -----
interface psm_out_if;
  logic              valid;
  logic              ready;
  psm_pkg::sample_t  mix_left;
  psm_pkg::sample_t  mix_right;
  logic              clipped;

  modport source (output valid, mix_left, mix_right, clipped, input ready);
  modport sink (input valid, mix_left, mix_right, clipped, output ready);
endinterface

// ----- src/psm_cfg_if.sv -----
interface psm_cfg_if;
  logic                valid;
  logic                ready;
  psm_pkg::cfg_idx_t   index;
  psm_pkg::gain_t      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/psm_gain_regs.sv -----
module psm_gain_regs (
  input  logic           clk,
  input  logic           rst_n,
  psm_cfg_if.sink        cfg,
  output psm_pkg::gain_t gains_left [psm_pkg::MAX_SOURCES],
  output psm_pkg::gain_t gains_right[psm_pkg::MAX_SOURCES]
);

  psm_pkg::gain_t   gain_reg_r[psm_pkg::REG_COUNT];
  logic             wr_en;
  psm_pkg::reg_idx_t wr_idx;

  // writes are always taken, indexes past the file are dropped
  assign cfg.ready = 1'b1;
  assign wr_en  = cfg.valid && !cfg.index[psm_pkg::CFG_IDX_W-1];
  assign wr_idx = cfg.index[psm_pkg::REG_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < psm_pkg::REG_COUNT; i++) begin
        gain_reg_r[i] <= '0;
      end
    end else if (wr_en) begin
      gain_reg_r[wr_idx] <= cfg.data;
    end
  end

  // even registers feed the left mix, odd ones the right
  always_comb begin
    for (int s = 0; s < psm_pkg::MAX_SOURCES; s++) begin
      gains_left[s]  = gain_reg_r[2*s];
      gains_right[s] = gain_reg_r[2*s+1];
    end
  end

endmodule

// ----- src/psm_scale.sv -----
module psm_scale (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  psm_pkg::sample_t samp_left  [psm_pkg::MAX_SOURCES],
  input  psm_pkg::sample_t samp_right [psm_pkg::MAX_SOURCES],
  input  psm_pkg::gain_t   gains_left [psm_pkg::MAX_SOURCES],
  input  psm_pkg::gain_t   gains_right[psm_pkg::MAX_SOURCES],
  output logic             out_valid,
  input  logic             out_ready,
  output psm_pkg::term_t   term_left  [psm_pkg::MAX_SOURCES],
  output psm_pkg::term_t   term_right [psm_pkg::MAX_SOURCES]
);

  psm_pkg::prod_t prod_left_nxt [psm_pkg::MAX_SOURCES];
  psm_pkg::prod_t prod_right_nxt[psm_pkg::MAX_SOURCES];
  psm_pkg::term_t term_left_r   [psm_pkg::MAX_SOURCES];
  psm_pkg::term_t term_right_r  [psm_pkg::MAX_SOURCES];
  logic           vld_r;

  assign in_ready = !vld_r || out_ready;

  // one multiplier per sample, unused sources give zero
  always_comb begin
    for (int s = 0; s < psm_pkg::MAX_SOURCES; s++) begin
      if (s < psm_pkg::SOURCE_COUNT) begin
        prod_left_nxt[s]  = samp_left[s]  * $signed({1'b0, gains_left[s]});
        prod_right_nxt[s] = samp_right[s] * $signed({1'b0, gains_right[s]});
      end else begin
        prod_left_nxt[s]  = '0;
        prod_right_nxt[s] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  // arithmetic shift by the gain's fraction bits is a plain bit-select
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int s = 0; s < psm_pkg::MAX_SOURCES; s++) begin
        term_left_r[s]  <= prod_left_nxt[s][psm_pkg::GAIN_SHIFT +: psm_pkg::TERM_W];
        term_right_r[s] <= prod_right_nxt[s][psm_pkg::GAIN_SHIFT +: psm_pkg::TERM_W];
      end
    end
  end

  assign out_valid  = vld_r;
  assign term_left  = term_left_r;
  assign term_right = term_right_r;

endmodule

// ----- src/psm_accum.sv -----
module psm_accum (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  psm_pkg::term_t term_left [psm_pkg::MAX_SOURCES],
  input  psm_pkg::term_t term_right[psm_pkg::MAX_SOURCES],
  output logic           out_valid,
  input  logic           out_ready,
  output psm_pkg::sum_t  sum_left,
  output psm_pkg::sum_t  sum_right
);

  psm_pkg::pair_t pair_left_nxt [psm_pkg::PAIR_COUNT];
  psm_pkg::pair_t pair_right_nxt[psm_pkg::PAIR_COUNT];
  psm_pkg::pair_t pair_left_r   [psm_pkg::PAIR_COUNT];
  psm_pkg::pair_t pair_right_r  [psm_pkg::PAIR_COUNT];
  psm_pkg::sum_t  sum_left_nxt;
  psm_pkg::sum_t  sum_right_nxt;
  psm_pkg::sum_t  sum_left_r;
  psm_pkg::sum_t  sum_right_r;
  logic           pair_vld_r;
  logic           sum_vld_r;
  logic           pair_ready;

  assign pair_ready = !sum_vld_r || out_ready;
  assign in_ready   = !pair_vld_r || pair_ready;

  // first level: neighbouring terms added in pairs
  always_comb begin
    for (int p = 0; p < psm_pkg::PAIR_COUNT; p++) begin
      pair_left_nxt[p]  = psm_pkg::pair_t'(term_left[2*p])
                        + psm_pkg::pair_t'(term_left[2*p+1]);
      pair_right_nxt[p] = psm_pkg::pair_t'(term_right[2*p])
                        + psm_pkg::pair_t'(term_right[2*p+1]);
    end
  end

  // second level: pair sums into the full-width total
  always_comb begin
    sum_left_nxt  = '0;
    sum_right_nxt = '0;
    for (int p = 0; p < psm_pkg::PAIR_COUNT; p++) begin
      sum_left_nxt  = sum_left_nxt  + psm_pkg::sum_t'(pair_left_r[p]);
      sum_right_nxt = sum_right_nxt + psm_pkg::sum_t'(pair_right_r[p]);
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_vld_r <= 1'b0;
      sum_vld_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        pair_vld_r <= in_valid;
      end
      if (pair_ready) begin
        sum_vld_r <= pair_vld_r;
      end
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pair_left_r  <= pair_left_nxt;
      pair_right_r <= pair_right_nxt;
    end
    if (pair_ready && pair_vld_r) begin
      sum_left_r  <= sum_left_nxt;
      sum_right_r <= sum_right_nxt;
    end
  end

  assign out_valid = sum_vld_r;
  assign sum_left  = sum_left_r;
  assign sum_right = sum_right_r;

endmodule

// ----- src/psm_sat.sv -----
module psm_sat (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  psm_pkg::sum_t sum_left,
  input  psm_pkg::sum_t sum_right,
  psm_out_if.source     out
);

  logic             hi_left, lo_left, hi_right, lo_right;
  psm_pkg::sample_t mix_left_nxt, mix_right_nxt;
  psm_pkg::sample_t mix_left_r, mix_right_r;
  logic             clip_nxt, clip_r;
  logic             vld_r;

  assign in_ready = !vld_r || out.ready;

  // range checks against the 16-bit rails
  assign hi_left  = sum_left  > psm_pkg::sum_t'(psm_pkg::SAMPLE_MAX);
  assign lo_left  = sum_left  < psm_pkg::sum_t'(psm_pkg::SAMPLE_MIN);
  assign hi_right = sum_right > psm_pkg::sum_t'(psm_pkg::SAMPLE_MAX);
  assign lo_right = sum_right < psm_pkg::sum_t'(psm_pkg::SAMPLE_MIN);

  // clamp each side, flag if either was clamped
  always_comb begin
    if (hi_left) begin
      mix_left_nxt = psm_pkg::SAMPLE_MAX;
    end else if (lo_left) begin
      mix_left_nxt = psm_pkg::SAMPLE_MIN;
    end else begin
      mix_left_nxt = sum_left[psm_pkg::SAMPLE_W-1:0];
    end
    if (hi_right) begin
      mix_right_nxt = psm_pkg::SAMPLE_MAX;
    end else if (lo_right) begin
      mix_right_nxt = psm_pkg::SAMPLE_MIN;
    end else begin
      mix_right_nxt = sum_right[psm_pkg::SAMPLE_W-1:0];
    end
    clip_nxt = hi_left || lo_left || hi_right || lo_right;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  // output register holds the word until it is taken
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mix_left_r  <= mix_left_nxt;
      mix_right_r <= mix_right_nxt;
      clip_r      <= clip_nxt;
    end
  end

  assign out.valid     = vld_r;
  assign out.mix_left  = mix_left_r;
  assign out.mix_right = mix_right_r;
  assign out.clipped   = clip_r;

endmodule

// ----- src/panned_stereo_sample_mixer.sv -----
// channel  dir  modport  payload
// in_ch    in   sink     src0..3 left/right, 16-bit signed samples
// out_ch   out  source   mix_left, mix_right (16-bit signed), clipped
// cfg_ch   in   sink     index (4 bits), data (9-bit Q1.8 gain)
//
// one word per cycle in and out unless out_ch stalls; a word passes the
// multiplier stage, two adder-tree stages and the saturating output register
// synchronous active-low reset empties every stage and zeroes all gains
// each stage has its own valid and moves whenever the stage after it is free,
// so a stall on out_ch backs up stage by stage and bubbles close up
// cfg_ch is always ready; an index of eight or more is ignored
module panned_stereo_sample_mixer (
  input  logic      clk,
  input  logic      rst_n,
  psm_in_if.sink    in_ch,
  psm_out_if.source out_ch,
  psm_cfg_if.sink   cfg_ch
);

  psm_pkg::gain_t   gains_left [psm_pkg::MAX_SOURCES];
  psm_pkg::gain_t   gains_right[psm_pkg::MAX_SOURCES];
  psm_pkg::sample_t samp_left  [psm_pkg::MAX_SOURCES];
  psm_pkg::sample_t samp_right [psm_pkg::MAX_SOURCES];
  psm_pkg::term_t   term_left  [psm_pkg::MAX_SOURCES];
  psm_pkg::term_t   term_right [psm_pkg::MAX_SOURCES];
  psm_pkg::sum_t    sum_left;
  psm_pkg::sum_t    sum_right;
  logic             scale_valid;
  logic             acc_ready;
  logic             acc_valid;
  logic             sat_ready;
  logic             sum_ovf;

  // unpack the input word per source
  assign samp_left[0]  = in_ch.src0_left;
  assign samp_right[0] = in_ch.src0_right;
  assign samp_left[1]  = in_ch.src1_left;
  assign samp_right[1] = in_ch.src1_right;
  assign samp_left[2]  = in_ch.src2_left;
  assign samp_right[2] = in_ch.src2_right;
  assign samp_left[3]  = in_ch.src3_left;
  assign samp_right[3] = in_ch.src3_right;

  // gain registers
  psm_gain_regs u_gain_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_ch),
    .gains_left  (gains_left),
    .gains_right (gains_right)
  );

  // multiply and shift
  psm_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .samp_left   (samp_left),
    .samp_right  (samp_right),
    .gains_left  (gains_left),
    .gains_right (gains_right),
    .out_valid   (scale_valid),
    .out_ready   (acc_ready),
    .term_left   (term_left),
    .term_right  (term_right)
  );

  // adder tree
  psm_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (scale_valid),
    .in_ready   (acc_ready),
    .term_left  (term_left),
    .term_right (term_right),
    .out_valid  (acc_valid),
    .out_ready  (sat_ready),
    .sum_left   (sum_left),
    .sum_right  (sum_right)
  );

  // saturation and output register
  psm_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (acc_valid),
    .in_ready  (sat_ready),
    .sum_left  (sum_left),
    .sum_right (sum_right),
    .out       (out_ch)
  );

  // either total outside the 16-bit range
  assign sum_ovf = (sum_left  > psm_pkg::sum_t'(psm_pkg::SAMPLE_MAX))
                || (sum_left  < psm_pkg::sum_t'(psm_pkg::SAMPLE_MIN))
                || (sum_right > psm_pkg::sum_t'(psm_pkg::SAMPLE_MAX))
                || (sum_right < psm_pkg::sum_t'(psm_pkg::SAMPLE_MIN));

  // a clipped word sits on a rail on at least one side
  a_clip_on_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.clipped) |->
      (out_ch.mix_left == psm_pkg::SAMPLE_MAX || out_ch.mix_left == psm_pkg::SAMPLE_MIN ||
       out_ch.mix_right == psm_pkg::SAMPLE_MAX || out_ch.mix_right == psm_pkg::SAMPLE_MIN))
    else $error("clipped word without a railed side");

  // output valid only rises from a loaded adder stage
  a_out_from_acc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(acc_valid))
    else $error("output word appeared without an adder result");

  // clip flag follows the range of the total that was loaded
  a_clip_tracks_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_valid && sat_ready) |=> (out_ch.clipped == $past(sum_ovf)))
    else $error("clip flag does not match the loaded total");

endmodule
